FILE: design/ffst_pkg.sv
package ffst_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int POS_W       = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  // Wide enough for a start plus a length from the 16-bit ports or the table.
  localparam int WW          = ((POS_W > 16) ? POS_W : 16) + 1;
  localparam int END_W       = POS_W + 1;
  localparam int KEY_W       = POS_W + END_W + IDX_W;

  localparam logic [WW-1:0] POS_MASK_W = WW'((64'd1 << POS_W) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_LOOKUP  = 3'd2,
    OP_FIND    = 3'd3,
    OP_COMPACT = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_BOUNDS    = 3'd2,
    ST_COLLIDE   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic pick_apply;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [2:0] op;
    logic       scan_last;
    logic       best_found;
    logic       hit;
    logic       out_free;
  } sts_t;

  function automatic logic [WW-1:0] eff_size(input logic [15:0] size);
    logic [WW-1:0] v;
    v = WW'(size);
    return (v > POS_MASK_W) ? POS_MASK_W : v;
  endfunction

endpackage

FILE: design/ffst_ctrl.sv
module ffst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ffst_pkg::sts_t sts,
  output ffst_pkg::ctl_t ctl
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PICK  = 5'b00100,
    S_APPLY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        // The opcode is latched on load, so the route is known from the first
        // scan cycle on: table scans for add, remove and lookup, ordered picks
        // for find and compact, straight to the result for anything else.
        unique case (sts.op)
          ffst_pkg::OP_ADD, ffst_pkg::OP_REMOVE, ffst_pkg::OP_LOOKUP: begin
            if (sts.scan_last) state_nxt = S_DONE;
          end
          ffst_pkg::OP_FIND, ffst_pkg::OP_COMPACT: begin
            state_nxt = sts.scan_last ? S_APPLY : S_PICK;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PICK: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        ctl.pick_apply = sts.best_found;
        if (!sts.best_found || (sts.op == ffst_pkg::OP_FIND && sts.hit)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PICK;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/ffst_dp.sv
module ffst_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ffst_pkg::ctl_t         ctl,
  output ffst_pkg::sts_t         sts,
  input  logic [2:0]             in_cmd,
  input  logic signed [15:0]     in_seg_id,
  input  logic [15:0]            in_seg_start,
  input  logic [15:0]            in_seg_length,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_status,
  output logic [15:0]            out_found_start,
  output logic [15:0]            out_found_length,
  output logic [15:0]            out_used_total
);

  localparam int N  = ffst_pkg::MAX_ENTRIES;
  localparam int PW = ffst_pkg::POS_W;
  localparam int IW = ffst_pkg::IDX_W;
  localparam int WW = ffst_pkg::WW;
  localparam int EW = ffst_pkg::END_W;
  localparam int KW = ffst_pkg::KEY_W;

  logic [15:0]   size_r;
  logic [N-1:0]  v_r;
  logic [15:0]   id_r    [N];
  logic [PW-1:0] beg_r   [N];
  logic [PW-1:0] span_r  [N];
  logic [PW-1:0] shadow_r[N];
  logic [PW-1:0] used_r;

  logic [2:0]    cmd_r;
  logic [15:0]   sid_r, sst_r, sln_r;

  logic [IW-1:0] idx_r;
  logic          match_r, free_r, coll_r;
  logic [IW-1:0] match_idx_r, free_idx_r;
  logic [PW-1:0] match_b_r, match_s_r;

  logic          have_last_r, best_r, hit_r;
  logic [KW-1:0] last_key_r, best_key_r;
  logic [IW-1:0] best_idx_r;
  logic [PW-1:0] best_b_r, best_s_r;
  logic [WW-1:0] mark_r, pos_r;

  logic          ov_r;
  logic [2:0]    ost_r;
  logic [15:0]   ofs_r, ofl_r;

  // Entry under the scan pointer.
  logic          cur_v;
  logic [PW-1:0] cur_b, cur_s;
  logic [EW-1:0] cur_end;
  logic [KW-1:0] cur_key;
  logic [WW-1:0] st_w, ln_w, cur_b_w, cur_end_w, eff_w, best_b_w;
  logic          cand, hit;

  assign cur_v     = v_r[idx_r];
  assign cur_b     = beg_r[idx_r];
  assign cur_s     = span_r[idx_r];
  assign cur_end   = EW'(cur_b) + EW'(cur_s);
  assign cur_key   = {cur_b, cur_end, idx_r};
  assign st_w      = WW'(sst_r);
  assign ln_w      = WW'(sln_r);
  assign cur_b_w   = WW'(cur_b);
  assign cur_end_w = WW'(cur_end);
  assign eff_w     = ffst_pkg::eff_size(size_r);
  assign best_b_w  = WW'(best_b_r);

  // Next entry in (start, end, index) order after the last one taken.
  assign cand = cur_v && (!have_last_r || cur_key > last_key_r) &&
                (!best_r || cur_key < best_key_r);
  assign hit  = (best_b_w >= mark_r) && (best_b_w - mark_r >= ln_w);

  assign sts.op         = cmd_r;
  assign sts.scan_last  = (idx_r == ffst_pkg::LAST_IDX);
  assign sts.best_found = best_r;
  assign sts.hit        = hit;
  assign sts.out_free   = !ov_r || !out_stall;

  // Result of the command.
  logic [2:0]  f_st;
  logic [15:0] f_fs, f_fl;
  logic        f_add, f_rem;

  always_comb begin
    f_st  = ffst_pkg::ST_NOT_FOUND;
    f_fs  = '0;
    f_fl  = '0;
    f_add = 1'b0;
    f_rem = 1'b0;
    unique case (cmd_r)
      ffst_pkg::OP_ADD: begin
        priority if (match_r)              f_st = ffst_pkg::ST_DUP;
        else if (st_w + ln_w > eff_w)      f_st = ffst_pkg::ST_BOUNDS;
        else if (coll_r)                   f_st = ffst_pkg::ST_COLLIDE;
        else if (!free_r)                  f_st = ffst_pkg::ST_FULL;
        else begin
          f_st  = ffst_pkg::ST_OK;
          f_add = 1'b1;
        end
      end
      ffst_pkg::OP_REMOVE: begin
        if (match_r) begin
          f_st  = ffst_pkg::ST_OK;
          f_rem = 1'b1;
        end
      end
      ffst_pkg::OP_LOOKUP: begin
        if (match_r) begin
          f_st = ffst_pkg::ST_OK;
          f_fs = 16'(match_b_r);
          f_fl = 16'(match_s_r);
        end
      end
      ffst_pkg::OP_FIND: begin
        if (hit_r || (mark_r <= eff_w && eff_w - mark_r >= ln_w)) begin
          f_st = ffst_pkg::ST_OK;
          f_fs = 16'(mark_r);
        end
      end
      ffst_pkg::OP_COMPACT: f_st = ffst_pkg::ST_OK;
      default:              f_st = ffst_pkg::ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 16'hFFFF;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      used_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ctl.finish) begin
        ov_r <= 1'b1;
        if (f_add) begin
          v_r[free_idx_r] <= 1'b1;
          used_r          <= used_r + PW'(sln_r);
        end
        if (f_rem) begin
          v_r[match_idx_r] <= 1'b0;
          used_r           <= used_r - match_s_r;
        end
      end else if (ov_r && !out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      ost_r <= f_st;
      ofs_r <= f_fs;
      ofl_r <= f_fl;
      if (f_add) begin
        id_r[free_idx_r]   <= sid_r;
        beg_r[free_idx_r]  <= PW'(sst_r);
        span_r[free_idx_r] <= PW'(sln_r);
      end
      if (cmd_r == ffst_pkg::OP_COMPACT) begin
        for (int i = 0; i < N; i++) begin
          if (v_r[i]) beg_r[i] <= shadow_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r       <= in_cmd;
      sid_r       <= in_seg_id;
      sst_r       <= in_seg_start;
      sln_r       <= in_seg_length;
      have_last_r <= 1'b0;
      hit_r       <= 1'b0;
      mark_r      <= '0;
      pos_r       <= '0;
    end
    if (ctl.load || ctl.pick_apply) begin
      idx_r   <= '0;
      match_r <= 1'b0;
      free_r  <= 1'b0;
      coll_r  <= 1'b0;
      best_r  <= 1'b0;
    end
    if (ctl.pick_apply) begin
      if (cmd_r == ffst_pkg::OP_FIND && hit) begin
        hit_r <= 1'b1;
      end else begin
        have_last_r          <= 1'b1;
        last_key_r           <= best_key_r;
        mark_r               <= best_b_w + WW'(best_s_r);
        shadow_r[best_idx_r] <= PW'(pos_r);
        pos_r                <= pos_r + WW'(best_s_r);
      end
    end
    if (ctl.scan_step) begin
      idx_r <= (idx_r == ffst_pkg::LAST_IDX) ? '0 : idx_r + 1'b1;
      if (cur_v && id_r[idx_r] == sid_r) begin
        match_r     <= 1'b1;
        match_idx_r <= idx_r;
        match_b_r   <= cur_b;
        match_s_r   <= cur_s;
      end
      if (!cur_v && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (cur_v && !(st_w + ln_w <= cur_b_w || st_w >= cur_end_w)) coll_r <= 1'b1;
      if (cand) begin
        best_r     <= 1'b1;
        best_key_r <= cur_key;
        best_idx_r <= idx_r;
        best_b_r   <= cur_b;
        best_s_r   <= cur_s;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_found_start  = ofs_r;
  assign out_found_length = ofl_r;
  assign out_used_total   = 16'(used_r);

endmodule

FILE: design/first_fit_segment_tracker.sv
// Channel  Direction  Handshake         Beat
// in_      input      in_valid/in_stall cmd, seg_id, seg_start, seg_length
// out_     output     out_valid/out_stall status, found_start, found_length, used_total
// cfg_     input      cfg_we            array_size
//
// Add, remove and lookup take one pass over the table.
// Find and compact pick entries in start order, one table pass per pick; one item
// is in work at a time.
// Synchronous active-low reset empties the table and sets the size to 65535.
// A result waits in the output register; a stalled result holds the next one back.
module first_fit_segment_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic signed [15:0] in_seg_id,
  input  logic [15:0]        in_seg_start,
  input  logic [15:0]        in_seg_length,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [15:0]        out_found_start,
  output logic [15:0]        out_found_length,
  output logic [15:0]        out_used_total,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  ffst_pkg::ctl_t ctl;
  ffst_pkg::sts_t sts;

  ffst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ffst_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_seg_id        (in_seg_id),
    .in_seg_start     (in_seg_start),
    .in_seg_length    (in_seg_length),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found_start  (out_found_start),
    .out_found_length (out_found_length),
    .out_used_total   (out_used_total)
  );

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ffst_pkg::ST_FULL)
    else $error("status code out of range");

  a_fail_no_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffst_pkg::ST_OK |-> out_found_length == 16'd0)
    else $error("length reported on a failed command");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a command in work");

endmodule
